// ----- src/x86ea_pkg.sv -----
package x86ea_pkg;

   localparam int GPR_COUNT = 8;
   localparam int GPR_WIDTH = 32;
   localparam int GPR_AW    = $clog2(GPR_COUNT);

   localparam logic       OP_LOAD   = 1'b0;
   localparam logic       OP_DECODE = 1'b1;

   localparam logic [1:0] MOD_NO_DISP  = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP_FULL = 2'd2;
   localparam logic [1:0] MOD_REGISTER = 2'd3;

   localparam logic [2:0] RM_SIB     = 3'd4;
   localparam logic [2:0] RM_DIRECT32 = 3'd5;
   localparam logic [2:0] RM_DIRECT16 = 3'd6;

   localparam logic [2:0] SIB_NO_INDEX = 3'd4;
   localparam logic [2:0] SIB_NO_BASE  = 3'd5;

   localparam logic [2:0] REG_BX = 3'd3;
   localparam logic [2:0] REG_SP = 3'd4;
   localparam logic [2:0] REG_BP = 3'd5;
   localparam logic [2:0] REG_SI = 3'd6;
   localparam logic [2:0] REG_DI = 3'd7;

   localparam logic [2:0] SEG_SS = 3'd2;
   localparam logic [2:0] SEG_DS = 3'd3;

   localparam logic [31:0] SEXT_FILL = 32'hffffff00;
   localparam logic [15:0] LOW_HALF  = 16'hffff;

   typedef struct packed {
      logic        op;
      logic [2:0]  reg_index;
      logic [31:0] reg_value;
      logic [7:0]  modrm_byte;
      logic [7:0]  sib_byte;
      logic [31:0] disp_bytes;
      logic        addr32;
      logic        seg_override_valid;
      logic [2:0]  seg_override;
      logic        wide_operand;
   } req_type;

   typedef struct packed {
      logic        is_register;
      logic [2:0]  reg_or_segment;
      logic [31:0] offset;
      logic [2:0]  length;
      logic        wide_operand_out;
   } rsp_type;

   function automatic logic [31:0] sext8(input logic [7:0] b);
      return b[7] ? (SEXT_FILL | {24'd0, b}) : {24'd0, b};
   endfunction

   function automatic logic [2:0] pick_seg(input logic ovr, input logic [2:0] ovr_seg,
                                           input logic stack);
      logic [2:0] seg;
      if (ovr) begin
         seg = ovr_seg;
      end else if (stack) begin
         seg = SEG_SS;
      end else begin
         seg = SEG_DS;
      end
      return seg;
   endfunction

   function automatic logic [GPR_AW-1:0] base_select(input req_type r);
      logic [GPR_AW-1:0] sel;
      if (r.addr32) begin
         sel = (r.modrm_byte[2:0] == RM_SIB) ? r.sib_byte[2:0] : r.modrm_byte[2:0];
      end else begin
         case (r.modrm_byte[2:0])
            3'd2, 3'd3, 3'd6: sel = REG_BP;
            3'd4:             sel = REG_SI;
            3'd5:             sel = REG_DI;
            default:          sel = REG_BX;
         endcase
      end
      return sel;
   endfunction

   function automatic logic [GPR_AW-1:0] index_select(input req_type r);
      logic [GPR_AW-1:0] sel;
      if (r.addr32) begin
         sel = r.sib_byte[5:3];
      end else begin
         sel = r.modrm_byte[0] ? REG_DI : REG_SI;
      end
      return sel;
   endfunction

endpackage

// ----- src/x86ea_ram.sv -----
module x86ea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr_a,
   input  logic [AddrW-1:0] rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- src/x86ea_decode.sv -----
module x86ea_decode (
   input  x86ea_pkg::req_type     req,
   input  logic [31:0]            base_value,
   input  logic [31:0]            index_value,
   output x86ea_pkg::rsp_type     rsp
);

   logic [1:0]  mode;
   logic [2:0]  rm;
   logic [1:0]  scale;
   logic [2:0]  sib_index;
   logic [2:0]  sib_base;
   logic [31:0] disp8;
   logic [31:0] disp;
   logic [31:0] index_term;
   logic [31:0] base_term;
   logic [15:0] disp16;
   logic [15:0] sum16;
   logic        no_base;
   logic        stack;

   always_comb begin
      mode       = req.modrm_byte[7:6];
      rm         = req.modrm_byte[2:0];
      scale      = req.sib_byte[7:6];
      sib_index  = req.sib_byte[5:3];
      sib_base   = req.sib_byte[2:0];
      disp8      = x86ea_pkg::sext8(req.disp_bytes[7:0]);
      disp       = '0;
      index_term = '0;
      base_term  = '0;
      disp16     = '0;
      sum16      = '0;
      no_base    = 1'b0;
      stack      = 1'b0;

      rsp.is_register      = 1'b0;
      rsp.reg_or_segment   = '0;
      rsp.offset           = '0;
      rsp.length           = 3'd1;
      rsp.wide_operand_out = req.wide_operand;

      if (mode == x86ea_pkg::MOD_REGISTER) begin
         rsp.is_register    = 1'b1;
         rsp.reg_or_segment = rm;
      end else if (req.addr32) begin
         if (mode == x86ea_pkg::MOD_NO_DISP && rm == x86ea_pkg::RM_DIRECT32) begin
            rsp.length = 3'd5;
            rsp.offset = req.disp_bytes;
         end else if (rm == x86ea_pkg::RM_SIB) begin
            no_base = (mode == x86ea_pkg::MOD_NO_DISP) && (sib_base == x86ea_pkg::SIB_NO_BASE);
            rsp.length = 3'd2;
            if (no_base || mode == x86ea_pkg::MOD_DISP_FULL) begin
               disp       = req.disp_bytes;
               rsp.length = 3'd6;
            end else if (mode == x86ea_pkg::MOD_DISP8) begin
               disp       = disp8;
               rsp.length = 3'd3;
            end
            if (sib_index != x86ea_pkg::SIB_NO_INDEX) begin
               index_term = index_value << scale;
            end
            if (!no_base) begin
               base_term = base_value;
               stack     = (sib_base == x86ea_pkg::REG_SP) || (sib_base == x86ea_pkg::REG_BP);
            end
            rsp.offset = disp + index_term + base_term;
         end else begin
            if (mode == x86ea_pkg::MOD_DISP8) begin
               disp       = disp8;
               rsp.length = 3'd2;
            end else if (mode == x86ea_pkg::MOD_DISP_FULL) begin
               disp       = req.disp_bytes;
               rsp.length = 3'd5;
            end
            stack      = (rm == x86ea_pkg::REG_BP);
            rsp.offset = base_value + disp;
         end
      end else begin
         if (mode == x86ea_pkg::MOD_NO_DISP && rm == x86ea_pkg::RM_DIRECT16) begin
            rsp.length = 3'd3;
            rsp.offset = {16'd0, req.disp_bytes[15:0] & x86ea_pkg::LOW_HALF};
         end else begin
            if (mode == x86ea_pkg::MOD_DISP8) begin
               disp16     = disp8[15:0];
               rsp.length = 3'd2;
            end else if (mode == x86ea_pkg::MOD_DISP_FULL) begin
               disp16     = req.disp_bytes[15:0];
               rsp.length = 3'd3;
            end
            sum16 = base_value[15:0] + disp16;
            if (!rm[2]) begin
               sum16 = sum16 + index_value[15:0];
            end
            stack      = (rm == 3'd2) || (rm == 3'd3) || (rm == 3'd6);
            rsp.offset = {16'd0, sum16};
         end
      end

      if (mode != x86ea_pkg::MOD_REGISTER) begin
         rsp.reg_or_segment = x86ea_pkg::pick_seg(req.seg_override_valid,
                                                  req.seg_override, stack);
      end
   end

endmodule

// ----- src/x86_modrm_effective_address_core.sv -----
// channel   ports                         direction  payload
// request   req_valid req_ready req_data  in         x86ea_pkg::req_type
// response  rsp_valid rsp_ready rsp_data  out        x86ea_pkg::rsp_type
//
// One transaction per cycle is taken while req_ready is high; a decode response is
// built from a register file read, then an address add into the response register.
// A register load writes at acceptance and gives no response; a decode accepted the
// next cycle sees the new value. Reset clears the register valid bits, so every
// register reads as zero until loaded. A stalled response holds the response register,
// and one more decode waits in the read stage before req_ready drops.
module x86_modrm_effective_address_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  x86ea_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output x86ea_pkg::rsp_type  rsp_data
);

   localparam int Aw = x86ea_pkg::GPR_AW;

   logic                            req_accept;
   logic                            read_en;
   logic                            write_en;
   logic                            slot_free;
   logic [Aw-1:0]                   base_addr;
   logic [Aw-1:0]                   index_addr;
   logic [x86ea_pkg::GPR_WIDTH-1:0] base_raw;
   logic [x86ea_pkg::GPR_WIDTH-1:0] index_raw;
   logic [x86ea_pkg::GPR_WIDTH-1:0] base_value;
   logic [x86ea_pkg::GPR_WIDTH-1:0] index_value;
   logic [x86ea_pkg::GPR_COUNT-1:0] loaded_ff;
   logic [x86ea_pkg::GPR_COUNT-1:0] loaded_in;
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   x86ea_pkg::req_type              s1_req_ff;
   logic                            s1_base_ok_ff;
   logic                            s1_index_ok_ff;
   x86ea_pkg::rsp_type              result;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   x86ea_pkg::rsp_type              rsp_data_ff;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || slot_free;
   assign req_accept = req_valid && req_ready;
   assign read_en    = req_accept && (req_data.op == x86ea_pkg::OP_DECODE);
   assign write_en   = req_accept && (req_data.op == x86ea_pkg::OP_LOAD);
   assign base_addr  = x86ea_pkg::base_select(req_data);
   assign index_addr = x86ea_pkg::index_select(req_data);

   x86ea_ram #(
      .WIDTH (x86ea_pkg::GPR_WIDTH),
      .DEPTH (x86ea_pkg::GPR_COUNT)
   ) u_gpr (
      .clock     (clock),
      .wr_en     (write_en),
      .wr_addr   (req_data.reg_index),
      .wr_data   (req_data.reg_value),
      .rd_en     (read_en),
      .rd_addr_a (base_addr),
      .rd_addr_b (index_addr),
      .rd_data_a (base_raw),
      .rd_data_b (index_raw)
   );

   always_comb begin
      loaded_in = loaded_ff;
      if (write_en) begin
         loaded_in[req_data.reg_index] = 1'b1;
      end
      if (read_en) begin
         s1_valid_in = 1'b1;
      end else if (slot_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = slot_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         s1_req_ff      <= req_data;
         s1_base_ok_ff  <= loaded_ff[base_addr];
         s1_index_ok_ff <= loaded_ff[index_addr];
      end
      if (slot_free && s1_valid_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign base_value  = s1_base_ok_ff ? base_raw : '0;
   assign index_value = s1_index_ok_ff ? index_raw : '0;

   x86ea_decode u_decode (
      .req         (s1_req_ff),
      .base_value  (base_value),
      .index_value (index_value),
      .rsp         (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
